FILE: design/ef_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ef_pkg
// Shared types and constants of the Elias-Fano encoder.
// ---------------------------------------------------------------------------
package ef_pkg;

   localparam int POSITION_BITS = 64;
   localparam logic [63:0] POS_MASK = {64{1'b1}} >> (64 - POSITION_BITS);

   localparam int WORD_BITS  = 64;
   localparam int INDEX_BITS = 58;
   localparam int ZERO_BITS  = 59;

   // request commands
   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   // register select (address bit 3)
   localparam logic REG_LOW_WIDTH     = 1'b0;
   localparam logic REG_MAX_POSITIONS = 1'b1;

   typedef enum logic [2:0] {
      KIND_LOW     = 3'd0,
      KIND_FULL    = 3'd1,
      KIND_PARTIAL = 3'd2,
      KIND_TOTAL   = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   // Everything one request produces. Order of results:
   //   add:    low, full word, error
   //   finish: partial word, low, total
   typedef struct packed {
      logic                   is_finish;
      logic                   low_en;
      logic [63:0]            low_data;
      logic [6:0]             low_cnt;
      logic                   word_en;
      logic [63:0]            word_data;
      logic [6:0]             word_bits;
      logic [ZERO_BITS-1:0]   zeros;
      logic                   tail_en;
      logic [63:0]            tail_data;
   } bundle_type;

endpackage

FILE: design/ef_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ef_front
// Accepts requests, splits positions and updates the high bit array state.
// ---------------------------------------------------------------------------
module ef_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [5:0]         low_width,
   input  logic [63:0]        max_positions,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_command,
   input  logic [63:0]        req_position,
   output logic               q_valid,
   input  logic               q_ready,
   output ef_pkg::bundle_type q_data
);
   import ef_pkg::*;

   // stage 1: split
   logic        s1_valid_ff, s1_valid_in;
   logic        s1_cmd_ff;
   logic [63:0] s1_shift_ff;
   logic [63:0] s1_low_ff;

   // stage 2: encoder state
   logic [63:0]           count_ff, count_in;
   logic [INDEX_BITS-1:0] hwi_ff, hwi_in;
   logic [63:0]           word_ff, word_in;
   logic [6:0]            offset_ff, offset_in;

   logic                  s2_fire;
   logic [63:0]           pos_m;
   logic [63:0]           upper;
   logic [INDEX_BITS-1:0] tgt_word;
   logic [5:0]            tgt_bit;
   logic                  advance;
   logic                  over;
   logic [INDEX_BITS-1:0] gap;
   bundle_type            bnd;

   assign s2_fire     = s1_valid_ff && q_ready;
   assign req_ready   = !s1_valid_ff || s2_fire;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s2_fire);
   assign pos_m       = req_position & POS_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && req_ready) begin
         s1_cmd_ff   <= req_command;
         s1_shift_ff <= pos_m >> low_width;
         s1_low_ff   <= pos_m & ~({64{1'b1}} << low_width);
      end
   end

   assign upper    = s1_shift_ff + count_ff;
   assign tgt_word = upper[63:6];
   assign tgt_bit  = upper[5:0];
   assign advance  = tgt_word > hwi_ff;
   assign gap      = tgt_word - hwi_ff - INDEX_BITS'(1);
   // count + 1 > max, with count + 1 wrapping to zero at the top
   assign over     = (count_ff != {64{1'b1}}) && (count_ff >= max_positions);

   always_comb begin
      count_in  = count_ff;
      hwi_in    = hwi_ff;
      word_in   = word_ff;
      offset_in = offset_ff;
      bnd       = '0;
      if (s1_cmd_ff == CMD_FINISH) begin
         bnd.is_finish = 1'b1;
         bnd.word_en   = 1'b1;
         bnd.word_data = word_ff;
         bnd.word_bits = offset_ff;
         bnd.low_en    = (low_width == 6'd0);
         bnd.low_data  = '0;
         bnd.low_cnt   = 7'(WORD_BITS);
         bnd.tail_en   = 1'b1;
         bnd.tail_data = {hwi_ff, 6'd0} + {57'd0, offset_ff};
         count_in  = '0;
         hwi_in    = '0;
         word_in   = '0;
         offset_in = '0;
      end else begin
         bnd.is_finish = 1'b0;
         bnd.low_en    = (low_width != 6'd0);
         bnd.low_data  = s1_low_ff;
         bnd.low_cnt   = {1'b0, low_width};
         bnd.word_en   = advance;
         bnd.word_data = word_ff;
         bnd.word_bits = 7'(WORD_BITS);
         bnd.zeros     = {1'b0, gap};
         bnd.tail_en   = over;
         bnd.tail_data = '0;
         hwi_in    = advance ? tgt_word : hwi_ff;
         word_in   = (advance ? 64'd0 : word_ff) | (64'd1 << tgt_bit);
         offset_in = {1'b0, tgt_bit} + 7'd1;
         count_in  = count_ff + 64'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hwi_ff    <= '0;
         word_ff   <= '0;
         offset_ff <= '0;
      end else if (s2_fire) begin
         count_ff  <= count_in;
         hwi_ff    <= hwi_in;
         word_ff   <= word_in;
         offset_ff <= offset_in;
      end
   end

   // a quiet add (no low field, no word, no error) only updates state
   assign q_valid = s1_valid_ff && (bnd.low_en || bnd.word_en || bnd.tail_en);
   assign q_data  = bnd;

endmodule

FILE: design/ef_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ef_queue
// Two-entry queue of result bundles between front and back.
// ---------------------------------------------------------------------------
module ef_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  ef_pkg::bundle_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output ef_pkg::bundle_type rd_data
);
   import ef_pkg::*;

   bundle_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        push, pop;

   assign wr_ready = (fill_ff != 2'd2);
   assign rd_valid = (fill_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: design/ef_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ef_back
// Walks the results of each bundle in order into the response register.
// ---------------------------------------------------------------------------
module ef_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  ef_pkg::bundle_type q_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_kind,
   output logic [63:0]        rsp_data,
   output logic [6:0]         rsp_bit_count,
   output logic [58:0]        rsp_zero_words_after,
   output logic               rsp_last
);
   import ef_pkg::*;

   bundle_type           bnd_ff;
   logic [2:0]           pend_ff, pend_in;
   logic [2:0]           pick, remain, after;
   logic                 out_load;

   logic                 valid_ff, valid_in;
   kind_type             kind_ff, kind_in;
   logic [63:0]          data_ff, data_in;
   logic [6:0]           bits_ff, bits_in;
   logic [ZERO_BITS-1:0] zeros_ff, zeros_in;
   logic                 last_ff, last_in;

   // first pending slot, one-hot
   assign pick     = pend_ff[0] ? 3'b001 : (pend_ff[1] ? 3'b010 : 3'b100);
   assign remain   = pend_ff & ~pick;
   assign out_load = (pend_ff != 3'd0) && (!valid_ff || rsp_ready);
   assign after    = out_load ? remain : pend_ff;
   assign q_ready  = (after == 3'd0);

   always_comb begin
      pend_in = after;
      if (q_valid && q_ready) begin
         if (q_data.is_finish) begin
            pend_in = {q_data.tail_en, q_data.low_en, q_data.word_en};
         end else begin
            pend_in = {q_data.tail_en, q_data.word_en, q_data.low_en};
         end
      end
   end

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      data_in  = data_ff;
      bits_in  = bits_ff;
      zeros_in = zeros_ff;
      last_in  = last_ff;
      if (out_load) begin
         valid_in = 1'b1;
         last_in  = (remain == 3'd0);
         zeros_in = '0;
         bits_in  = '0;
         data_in  = '0;
         if (pick[2]) begin
            kind_in = bnd_ff.is_finish ? KIND_TOTAL : KIND_ERROR;
            data_in = bnd_ff.tail_data;
         end else if (pick[0] ^ bnd_ff.is_finish) begin
            kind_in = KIND_LOW;
            data_in = bnd_ff.low_data;
            bits_in = bnd_ff.low_cnt;
         end else begin
            kind_in  = bnd_ff.is_finish ? KIND_PARTIAL : KIND_FULL;
            data_in  = bnd_ff.word_data;
            bits_in  = bnd_ff.word_bits;
            zeros_in = bnd_ff.zeros;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         pend_ff  <= pend_in;
         valid_ff <= valid_in;
      end
      if (q_valid && q_ready) begin
         bnd_ff <= q_data;
      end
      kind_ff  <= kind_in;
      data_ff  <= data_in;
      bits_ff  <= bits_in;
      zeros_ff <= zeros_in;
      last_ff  <= last_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_data             = data_ff;
   assign rsp_bit_count        = bits_ff;
   assign rsp_zero_words_after = zeros_ff;
   assign rsp_last             = last_ff;

   a_error_empty: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_ERROR |-> data_ff == 64'd0 && bits_ff == 7'd0)
      else $error("error result carries data");

   a_total_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_TOTAL |-> last_ff)
      else $error("total is not the last result of a finish");

   a_partial_not_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == KIND_PARTIAL |-> !last_ff)
      else $error("partial word marked last");

   a_zeros_full_only: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff != KIND_FULL |-> zeros_ff == '0)
      else $error("zero run on a result other than a full word");

endmodule

FILE: design/elias_fano_encoder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// elias_fano_encoder_core
// Elias-Fano encoder: low bit stream and run-compressed high bit words.
// ---------------------------------------------------------------------------
// The front accepts one request per clock unless the queue is full, splits
// the position in one stage and updates the high-word state in the next,
// handing a bundle of up to three results to a two-entry queue. The back
// emits one result per clock from it while rsp_ready is high, so a request
// holds the port for as many results as it has: none for an add with no low
// field that only sets a bit in the current word, typically one or two for
// an add, two or three for a finish. The single response port limits the
// sustained rate. Registers: low_width at byte address 0, max_positions at 8.
module elias_fano_encoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [63:0] req_position,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [63:0] rsp_data,
   output logic [6:0]  rsp_bit_count,
   output logic [58:0] rsp_zero_words_after,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ef_pkg::*;

   logic [5:0]  low_width_ff;
   logic [63:0] max_pos_ff;
   logic        csr_wr;

   logic        fq_valid, fq_ready;
   bundle_type  fq_data;
   logic        qb_valid, qb_ready;
   bundle_type  qb_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_width_ff <= '0;
         max_pos_ff   <= 64'd1;
      end else if (csr_wr) begin
         unique case (csr_paddr[3])
            REG_LOW_WIDTH:     low_width_ff <= csr_pwdata[5:0];
            REG_MAX_POSITIONS: max_pos_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3])
         REG_LOW_WIDTH:     csr_prdata = {58'd0, low_width_ff};
         REG_MAX_POSITIONS: csr_prdata = max_pos_ff;
         default:           csr_prdata = '0;
      endcase
   end

   ef_front u_front (
      .clock         (clock),
      .reset         (reset),
      .low_width     (low_width_ff),
      .max_positions (max_pos_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_position  (req_position),
      .q_valid       (fq_valid),
      .q_ready       (fq_ready),
      .q_data        (fq_data)
   );

   ef_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  (fq_data),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  (qb_data)
   );

   ef_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (qb_valid),
      .q_ready              (qb_ready),
      .q_data               (qb_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data             (rsp_data),
      .rsp_bit_count        (rsp_bit_count),
      .rsp_zero_words_after (rsp_zero_words_after),
      .rsp_last             (rsp_last)
   );

endmodule

FILE: verif/ef_stream_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ef_stream_checker
// Watches the request, response and register ports of the Elias-Fano
// encoder. Predicts the responses of each accepted request from its own copy
// of the encoder state, then compares every accepted response field by field
// with the oldest prediction.
// ---------------------------------------------------------------------------
module ef_stream_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_command,
   input  logic [63:0]                  req_position,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [2:0]                   rsp_kind,
   input  logic [63:0]                  rsp_data,
   input  logic [6:0]                   rsp_bit_count,
   input  logic [ef_pkg::ZERO_BITS-1:0] rsp_zero_words_after,
   input  logic                         rsp_last,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [3:0]                   csr_paddr,
   input  logic [63:0]                  csr_pwdata,
   input  logic                         csr_pready,
   output int                           mismatches,
   output int                           outstanding
);
   import ef_pkg::*;

   typedef struct packed {
      kind_type               kind;
      logic [63:0]            data;
      logic [6:0]             bit_count;
      logic [ZERO_BITS-1:0]   zeros;
      logic                   last;
   } ef_result_type;

   ef_result_type expected_results[$];

   // register copies
   logic [5:0]            low_width;
   logic [63:0]           max_positions;

   // encoder state copy
   logic [63:0]           positions_seen;
   logic [INDEX_BITS-1:0] word_index;
   logic [63:0]           open_word;
   logic [6:0]            open_bits;

   function automatic ef_result_type result_of(kind_type kind, logic [63:0] data,
                                               logic [6:0] bit_count,
                                               logic [ZERO_BITS-1:0] zeros);
      ef_result_type r;
      r.kind      = kind;
      r.data      = data;
      r.bit_count = bit_count;
      r.zeros     = zeros;
      r.last      = 1'b0;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic encode_request(input logic command, input logic [63:0] position);
      ef_result_type         produced[$];
      logic [63:0]           pos;
      logic [63:0]           upper;
      logic [INDEX_BITS-1:0] target_word;
      logic [INDEX_BITS-1:0] skipped;
      logic [5:0]            target_bit;
      pos = position & POS_MASK;
      if (command == CMD_FINISH) begin
         produced.push_back(result_of(KIND_PARTIAL, open_word, open_bits, '0));
         // no low stream: a single zero word stands in for it
         if (low_width == 6'd0)
            produced.push_back(result_of(KIND_LOW, '0, 7'd64, '0));
         produced.push_back(result_of(KIND_TOTAL, {word_index, 6'b0} + 64'(open_bits),
                                      7'd0, '0));
         positions_seen = '0;
         word_index     = '0;
         open_word      = '0;
         open_bits      = '0;
      end else begin
         if (low_width != 6'd0)
            produced.push_back(result_of(KIND_LOW, pos & ~({64{1'b1}} << low_width),
                                         {1'b0, low_width}, '0));
         upper       = (pos >> low_width) + positions_seen;
         target_word = upper[63:6];
         target_bit  = upper[5:0];
         // a word at or behind the open one just sets the bit in the open word
         if (target_word > word_index) begin
            skipped = target_word - word_index - INDEX_BITS'(1);
            produced.push_back(result_of(KIND_FULL, open_word, 7'd64, {1'b0, skipped}));
            open_word  = '0;
            word_index = target_word;
         end
         open_word[target_bit] = 1'b1;
         open_bits      = {1'b0, target_bit} + 7'd1;
         positions_seen = positions_seen + 64'd1;
         if (positions_seen > max_positions)
            produced.push_back(result_of(KIND_ERROR, '0, 7'd0, '0));
      end
      if (produced.size() > 0)
         produced[produced.size() - 1].last = 1'b1;
      foreach (produced[i])
         expected_results.push_back(produced[i]);
   endtask

   task automatic check_response();
      ef_result_type want;
      if (expected_results.size() == 0) begin
         $error("response with none expected: kind %0d data %0h", rsp_kind, rsp_data);
         mismatches++;
      end else begin
         want = expected_results.pop_front();
         compare_field("kind", 64'(want.kind), 64'(rsp_kind));
         compare_field("data", want.data, rsp_data);
         compare_field("bit_count", 64'(want.bit_count), 64'(rsp_bit_count));
         compare_field("zero_words_after", 64'(want.zeros), 64'(rsp_zero_words_after));
         compare_field("last", 64'(want.last), 64'(rsp_last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_results.delete();
         low_width      = '0;
         max_positions  = 64'd1;
         positions_seen = '0;
         word_index     = '0;
         open_word      = '0;
         open_bits      = '0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_response();
         if (req_valid && req_ready)
            encode_request(req_command, req_position);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[3] == REG_MAX_POSITIONS)
               max_positions = csr_pwdata;
            else
               low_width = csr_pwdata[5:0];
         end
      end
      outstanding = expected_results.size();
   end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives directed and random position sequences and register settings into
// the Elias-Fano encoder, with random stalls on both ports, and reports the
// verdict from the checker's error count.
// ---------------------------------------------------------------------------
module tb_top;
   import ef_pkg::*;

   localparam int          WATCHDOG_LIMIT  = 3000;
   localparam int          LONG_HOLD       = 300;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          RANDOM_REQUESTS = 250;
   localparam logic [63:0] ALL_ONES        = {64{1'b1}};

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_command;
   logic [63:0]          req_position;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [2:0]           rsp_kind;
   logic [63:0]          rsp_data;
   logic [6:0]           rsp_bit_count;
   logic [ZERO_BITS-1:0] rsp_zero_words_after;
   logic                 rsp_last;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [3:0]           csr_paddr;
   logic [63:0]          csr_pwdata;
   logic [63:0]          csr_prdata;
   logic                 csr_pready;

   int mismatches;
   int outstanding;
   int accepted_requests = 0;
   int finishes          = 0;
   int responses         = 0;
   int register_writes   = 0;
   int issued            = 0;
   int idle_cycles       = 0;
   bit sender_steady     = 0;
   bit long_hold_done    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   elias_fano_encoder_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_position         (req_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data             (rsp_data),
      .rsp_bit_count        (rsp_bit_count),
      .rsp_zero_words_after (rsp_zero_words_after),
      .rsp_last             (rsp_last),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   ef_stream_checker checker_inst (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_command          (req_command),
      .req_position         (req_position),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_data             (rsp_data),
      .rsp_bit_count        (rsp_bit_count),
      .rsp_zero_words_after (rsp_zero_words_after),
      .rsp_last             (rsp_last),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_pready           (csr_pready),
      .mismatches           (mismatches),
      .outstanding          (outstanding)
   );

   // activity counters and the stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted_requests <= accepted_requests + 1;
            if (req_command == CMD_FINISH)
               finishes <= finishes + 1;
         end
         if (rsp_valid && rsp_ready)
            responses <= responses + 1;
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("elias_fano_encoder_core: mismatch");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 93)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic push_request(input logic command, input logic [63:0] position);
      int gap;
      gap = sender_steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= command;
      req_position <= position;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      issued++;
   endtask

   // wait until every predicted response is out, plus the pipeline depth
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic sel, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      register_writes++;
   endtask

   task automatic apply_settings(input logic [5:0] width, input logic [63:0] limit);
      write_register(REG_LOW_WIDTH, {58'd0, width});
      write_register(REG_MAX_POSITIONS, limit);
   endtask

   // response side: random stalls, plus one long hold-off while requests flow
   initial begin
      int run;
      int gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_requests >= 60 && req_valid) begin
            long_hold_done = 1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            run = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
            rsp_ready <= 1'b1;
            repeat (run) @(posedge clock);
            gap = idle_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int          directed_end;
      int          len;
      int          pick;
      int          r;
      logic [5:0]  width;
      logic [63:0] limit;
      logic [63:0] pos;
      logic [63:0] hop;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_command  <= CMD_ADD;
      req_position <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no low stream, one position allowed
      push_request(CMD_ADD, 64'd0);
      push_request(CMD_ADD, 64'd0);
      push_request(CMD_ADD, 64'd130);
      push_request(CMD_ADD, ALL_ONES);       // wraps behind the open word
      push_request(CMD_FINISH, ALL_ONES);
      push_request(CMD_FINISH, 64'd0);       // empty sequence
      drain();

      // widest low field, no limit
      apply_settings(6'd63, ALL_ONES);
      push_request(CMD_ADD, 64'd0);
      push_request(CMD_ADD, ALL_ONES);
      push_request(CMD_ADD, 64'h8000_0000_0000_0000);
      push_request(CMD_FINISH, 64'd0);
      drain();

      apply_settings(6'd4, 64'd3);
      push_request(CMD_ADD, 64'h10);
      push_request(CMD_ADD, 64'h13);
      push_request(CMD_ADD, 64'h3);
      push_request(CMD_ADD, 64'h10000);
      push_request(CMD_ADD, 64'h8000_0000_0000_0000);
      push_request(CMD_FINISH, 64'h5555_5555_5555_5555);
      drain();

      // jump to the last high word index
      apply_settings(6'd0, 64'd2);
      push_request(CMD_ADD, 64'hFFFF_FFFF_FFFF_FFC0);
      push_request(CMD_FINISH, 64'hAAAA_AAAA_AAAA_AAAA);
      directed_end = issued;

      width = 6'd0;
      while (issued < directed_end + RANDOM_REQUESTS) begin
         if (issued == directed_end || $urandom_range(0, 2) != 0) begin
            drain();
            r = $urandom_range(0, 9);
            if (r == 0)
               width = 6'd0;
            else if (r == 1)
               width = 6'd63;
            else if (r < 6)
               width = 6'($urandom_range(1, 8));
            else
               width = 6'($urandom_range(0, 63));
            case ($urandom_range(0, 3))
               0:       limit = 64'd1;
               1:       limit = ALL_ONES;
               2:       limit = 64'($urandom_range(1, 40));
               default: limit = random_word();
            endcase
            if (limit == 0)
               limit = 64'd1;
            apply_settings(width, limit);
         end
         sender_steady = ($urandom_range(0, 4) == 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 20);
         case ($urandom_range(0, 2))
            0:       pos = 64'd0;
            1:       pos = 64'($urandom_range(0, 5000)) << width;
            default: pos = random_word() >> $urandom_range(0, 63);
         endcase
         repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               r = $urandom_range(0, 99);
               if (r < 60)
                  hop = 64'($urandom_range(0, 2));
               else if (r < 90)
                  hop = 64'($urandom_range(3, 70));
               else
                  hop = 64'($urandom_range(2, 1000)) * 64;
               pos = pos + (hop << width) + (random_word() & ~(ALL_ONES << width));
            end else if (pick < 88) begin
               pos = pos - 64'($urandom_range(1, 300));
            end else if (pick < 95) begin
               pos = random_word();
            end
            if (pick >= 97)
               push_request(CMD_FINISH, random_word());
            else
               push_request(CMD_ADD, pos);
         end
         if ($urandom_range(0, 9) != 0)
            push_request(CMD_FINISH, random_word());
      end

      drain();
      repeat (10) @(posedge clock);
      $display("covered %0d requests (%0d finishes) across %0d register writes",
               accepted_requests, finishes, register_writes);
      $display("%0d responses compared, %0d errors", responses, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("elias_fano_encoder_core: match");
      else
         $display("elias_fano_encoder_core: mismatch");
      $finish;
   end

endmodule
